@@ rtl/integer_to_padded_text_top_macros.svh @@
// Assertion macros for the integer to padded text RTL.
`ifndef INTEGER_TO_PADDED_TEXT_TOP_MACROS_SVH
`define INTEGER_TO_PADDED_TEXT_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ITPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define ITPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/itpt_pkg.sv @@
// Constants and a helper function for the integer to padded text formatter.
package itpt_pkg;

  localparam int FLAG_ZERO   = 0;
  localparam int FLAG_SIGNED = 1;
  localparam int FLAG_PLUS   = 2;
  localparam int FLAG_SPACE  = 3;
  localparam int FLAG_LEFT   = 4;
  localparam int FLAG_PREFIX = 5;
  localparam int FLAG_LOWER  = 6;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_OCT = 6'd8;
  localparam logic [5:0] RADIX_HEX = 6'd16;

  localparam logic [5:0] DIGIT_HEX_X = 6'd33;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam int OUT_MAX = 63;

  function automatic logic [7:0] digit_char(input logic [5:0] digit, input logic lower);
    logic [7:0] d8;
    d8 = {2'b00, digit};
    if (digit < 6'd10) begin
      digit_char = CHAR_ZERO + d8;
    end else if (lower) begin
      digit_char = CHAR_LOWER_A + d8 - 8'd10;
    end else begin
      digit_char = CHAR_UPPER_A + d8 - 8'd10;
    end
  endfunction

endpackage

@@ rtl/itpt_div.sv @@
// Iterative restoring divider: one quotient bit per cycle by a 6-bit radix.
module itpt_div #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [5:0]            divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [5:0]            remainder
);

  localparam int CNTW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo_r;
  logic [5:0]            rem_r;
  logic [5:0]            div_r;
  logic [CNTW-1:0]       cnt_r;
  logic                  run_r;
  logic                  done_r;

  logic [6:0] trial;
  logic [6:0] diff;
  logic       ge;

  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        div_r <= divisor;
        cnt_r <= CNTW'(VALUE_BITS - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        quo_r <= {quo_r[VALUE_BITS-2:0], ge};
        rem_r <= ge ? diff[5:0] : trial[5:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/integer_to_padded_text_top.sv @@
// Top level of the printf-style integer field formatter.
//
// A request is taken at a rising edge where start is high and busy is low. It carries
// a value, a radix, a field width, a minimum digit count and seven format flags.
// The formatted text leaves one character per cycle on out_text_char, except where the
// block steps between sections; each character is marked by a one-cycle out_strobe,
// with out_last_char set on the final character. A radix outside 2 to 36 gives a
// single strobe with out_bad_radix set in the next cycle, and busy stays low for it.
// For a valid radix, digits come from one shared restoring divider that produces one
// quotient bit per cycle. After the digits the ST_CALC state sizes the field, then the
// characters follow, and each step between sections emits no character. The next
// request can be taken in the cycle after busy falls.
// The receiver cannot stall: every strobed character must be taken in its cycle.
// A synchronous reset drops any request in flight and clears the strobe.
`include "integer_to_padded_text_top_macros.svh"

module integer_to_padded_text_top #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 60
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [5:0]            in_radix,
  input  logic [5:0]            in_total_width,
  input  logic [5:0]            in_min_digits,
  input  logic [6:0]            in_format_flags,
  output logic                  out_strobe,
  output logic [7:0]            out_text_char,
  output logic                  out_last_char,
  output logic                  out_bad_radix
);

  localparam int NDW    = $clog2(VALUE_BITS + 1);
  localparam int CW_RAW = $clog2(MAX_FIELD + VALUE_BITS + 4);
  localparam int CW     = (CW_RAW > 7) ? CW_RAW : 7;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CALC, ST_EMIT} state_t;
  typedef enum logic [2:0] {
    PH_LEAD, PH_SIGN, PH_PFX, PH_ZPAD, PH_PREC, PH_DIG, PH_TRAIL
  } phase_t;

  state_t  state_r;
  phase_t  phase_r;
  phase_t  phase_nxt;

  logic [5:0]     radix_r;
  logic [5:0]     width_r;
  logic [5:0]     prec_r;
  logic           lower_r;
  logic           left_r;
  logic           zero_r;
  logic           has_sign_r;
  logic [7:0]     sign_ch_r;
  logic [1:0]     pfx_len_r;
  logic [NDW-1:0] nd_r;
  logic [CW-1:0]  pad_r;
  logic [CW-1:0]  pz_r;
  logic [CW-1:0]  lim_r;
  logic [CW-1:0]  k_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;

  logic           out_strobe_r;
  logic [7:0]     out_char_r;
  logic           out_last_r;
  logic           out_bad_r;

  logic [5:0]     stack_r [VALUE_BITS];

  logic                  accept;
  logic                  radix_ok;
  logic                  neg_c;
  logic [VALUE_BITS-1:0] mag_c;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [5:0]            div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [5:0]            div_rem;
  logic                  push;
  logic                  pop;

  logic [CW-1:0] prec_eff_c;
  logic [CW-1:0] fixed_c;
  logic [CW-1:0] total_c;
  logic [CW-1:0] pad_c;
  logic [CW-1:0] lim_c;
  logic          lead_mode;
  logic          last_c;
  logic [7:0]    cur_char;
  logic [7:0]    sign_ch_c;
  logic [1:0]    pfx_len_c;

  assign busy     = state_r != ST_IDLE;
  assign accept   = start && !busy;
  assign radix_ok = (in_radix >= itpt_pkg::RADIX_MIN) && (in_radix <= itpt_pkg::RADIX_MAX);
  assign neg_c    = in_format_flags[itpt_pkg::FLAG_SIGNED] && in_value[VALUE_BITS-1];
  assign mag_c    = neg_c ? (VALUE_BITS'(0) - in_value) : in_value;

  always_comb begin
    priority if (neg_c) begin
      sign_ch_c = itpt_pkg::CHAR_MINUS;
    end else if (in_format_flags[itpt_pkg::FLAG_PLUS]) begin
      sign_ch_c = itpt_pkg::CHAR_PLUS;
    end else if (in_format_flags[itpt_pkg::FLAG_SPACE]) begin
      sign_ch_c = itpt_pkg::CHAR_SPACE;
    end else begin
      sign_ch_c = itpt_pkg::CHAR_NUL;
    end
    priority if (!in_format_flags[itpt_pkg::FLAG_PREFIX]) begin
      pfx_len_c = 2'd0;
    end else if (in_radix == itpt_pkg::RADIX_HEX) begin
      pfx_len_c = 2'd2;
    end else if (in_radix == itpt_pkg::RADIX_OCT) begin
      pfx_len_c = 2'd1;
    end else begin
      pfx_len_c = 2'd0;
    end
  end

  assign div_start    = (accept && radix_ok) ||
                        ((state_r == ST_DIV) && div_done && (div_quo != '0));
  assign div_dividend = (state_r == ST_IDLE) ? mag_c : div_quo;
  assign div_divisor  = (state_r == ST_IDLE) ? in_radix : radix_r;

  itpt_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign lead_mode  = !zero_r && !left_r;
  assign prec_eff_c = (CW'(prec_r) > CW'(nd_r)) ? CW'(prec_r) : CW'(nd_r);
  assign fixed_c    = prec_eff_c + CW'(has_sign_r) + CW'(pfx_len_r);
  assign total_c    = (CW'(width_r) > fixed_c) ? CW'(width_r) : fixed_c;
  assign pad_c      = total_c - fixed_c;
  assign lim_c      = (total_c > CW'(itpt_pkg::OUT_MAX)) ? CW'(itpt_pkg::OUT_MAX) : total_c;
  assign last_c     = k_r == (lim_r - 1'b1);

  always_comb begin
    unique case (phase_r)
      PH_LEAD: begin
        phase_nxt = PH_SIGN;
        cnt_nxt   = CW'(has_sign_r);
      end
      PH_SIGN: begin
        phase_nxt = PH_PFX;
        cnt_nxt   = CW'(pfx_len_r);
      end
      PH_PFX: begin
        phase_nxt = PH_ZPAD;
        cnt_nxt   = zero_r ? pad_r : '0;
      end
      PH_ZPAD: begin
        phase_nxt = PH_PREC;
        cnt_nxt   = pz_r;
      end
      PH_PREC: begin
        phase_nxt = PH_DIG;
        cnt_nxt   = CW'(nd_r);
      end
      PH_DIG: begin
        phase_nxt = PH_TRAIL;
        cnt_nxt   = left_r ? pad_r : '0;
      end
      default: begin
        phase_nxt = PH_TRAIL;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    unique case (phase_r)
      PH_LEAD:  cur_char = itpt_pkg::CHAR_SPACE;
      PH_SIGN:  cur_char = sign_ch_r;
      PH_PFX:   cur_char = ((pfx_len_r == 2'd2) && (cnt_r == CW'(1))) ?
                           itpt_pkg::digit_char(itpt_pkg::DIGIT_HEX_X, lower_r) :
                           itpt_pkg::CHAR_ZERO;
      PH_ZPAD:  cur_char = itpt_pkg::CHAR_ZERO;
      PH_PREC:  cur_char = itpt_pkg::CHAR_ZERO;
      PH_DIG:   cur_char = itpt_pkg::digit_char(stack_r[0], lower_r);
      default:  cur_char = itpt_pkg::CHAR_SPACE;
    endcase
  end

  assign push = (state_r == ST_DIV) && div_done;
  assign pop  = (state_r == ST_EMIT) && (cnt_r != '0) && (phase_r == PH_DIG);

  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[0] <= div_rem;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_LEAD;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!radix_ok) begin
              out_strobe_r <= 1'b1;
              out_char_r   <= itpt_pkg::CHAR_NUL;
              out_last_r   <= 1'b1;
              out_bad_r    <= 1'b1;
            end else begin
              radix_r    <= in_radix;
              width_r    <= (in_total_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : in_total_width;
              prec_r     <= (in_min_digits > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : in_min_digits;
              lower_r    <= in_format_flags[itpt_pkg::FLAG_LOWER];
              left_r     <= in_format_flags[itpt_pkg::FLAG_LEFT];
              zero_r     <= in_format_flags[itpt_pkg::FLAG_ZERO] &&
                            !in_format_flags[itpt_pkg::FLAG_LEFT];
              has_sign_r <= sign_ch_c != itpt_pkg::CHAR_NUL;
              sign_ch_r  <= sign_ch_c;
              pfx_len_r  <= pfx_len_c;
              nd_r       <= '0;
              state_r    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            nd_r <= nd_r + 1'b1;
            if (div_quo == '0) begin
              state_r <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          pad_r   <= pad_c;
          pz_r    <= prec_eff_c - CW'(nd_r);
          lim_r   <= lim_c;
          k_r     <= '0;
          phase_r <= PH_LEAD;
          cnt_r   <= lead_mode ? pad_c : '0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (cnt_r == '0) begin
            phase_r <= phase_nxt;
            cnt_r   <= cnt_nxt;
            if (phase_r == PH_TRAIL) begin
              state_r <= ST_IDLE;
            end
          end else begin
            out_strobe_r <= 1'b1;
            out_char_r   <= cur_char;
            out_last_r   <= last_c;
            out_bad_r    <= 1'b0;
            cnt_r        <= cnt_r - 1'b1;
            k_r          <= k_r + 1'b1;
            if (last_c) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;
  assign out_bad_radix = out_bad_r;

  `ITPT_ASSERT_NOW(a_bad_radix_shape, out_strobe && out_bad_radix, out_last_char && (out_text_char == itpt_pkg::CHAR_NUL), "Bad radix result must be a lone NUL marked last.")
  `ITPT_ASSERT_NEXT(a_bad_radix_reply, accept && !radix_ok, out_strobe && out_bad_radix, "Bad radix request must answer in the next cycle.")
  `ITPT_ASSERT_NOW(a_mid_char_busy, out_strobe && !out_last_char, busy, "Block went idle before the last character.")
  `ITPT_ASSERT_NOW(a_last_char_idle, out_strobe && out_last_char, !busy, "Block still busy after the last character.")
  `ITPT_ASSERT_NOW(a_div_quiet_emit, state_r == ST_EMIT, !div_done, "Divider finished while characters are going out.")

endmodule

@@ test/tb_integer_to_padded_text_top.sv @@
// Self-checking testbench for the integer to padded text formatter.
module tb_integer_to_padded_text_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 238;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int FIELD_CAP    = 60;

  localparam logic [5:0] RADIX_DEC = 6'd10;

  localparam logic [6:0] F_ZERO   = 7'(1 << itpt_pkg::FLAG_ZERO);
  localparam logic [6:0] F_SIGNED = 7'(1 << itpt_pkg::FLAG_SIGNED);
  localparam logic [6:0] F_PLUS   = 7'(1 << itpt_pkg::FLAG_PLUS);
  localparam logic [6:0] F_SPACE  = 7'(1 << itpt_pkg::FLAG_SPACE);
  localparam logic [6:0] F_LEFT   = 7'(1 << itpt_pkg::FLAG_LEFT);
  localparam logic [6:0] F_PREFIX = 7'(1 << itpt_pkg::FLAG_PREFIX);
  localparam logic [6:0] F_LOWER  = 7'(1 << itpt_pkg::FLAG_LOWER);

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
    logic [5:0]  total_width;
    logic [5:0]  min_digits;
    logic [6:0]  flags;
  } fmt_request_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic       bad_radix;
  } text_char_t;

  class field_text_checker;
    text_char_t expected_text[$];
    int mismatches;

    function void note_request(fmt_request_t r);
      string       digit_set;
      logic [7:0]  rev_digits[$];
      logic [7:0]  text[$];
      logic [7:0]  sign_char;
      logic [31:0] mag;
      logic [31:0] base;
      int          width, prec, size, nd, n, i;
      bit          zero_pad, left;
      if (r.radix < itpt_pkg::RADIX_MIN || r.radix > itpt_pkg::RADIX_MAX) begin
        expected_text.push_back('{itpt_pkg::CHAR_NUL, 1'b1, 1'b1});
        return;
      end
      digit_set = r.flags[itpt_pkg::FLAG_LOWER] ? "0123456789abcdefghijklmnopqrstuvwxyz"
                                                : "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
      left = r.flags[itpt_pkg::FLAG_LEFT];
      zero_pad = r.flags[itpt_pkg::FLAG_ZERO] && !left;
      width = (r.total_width > FIELD_CAP) ? FIELD_CAP : int'(r.total_width);
      prec = (r.min_digits > FIELD_CAP) ? FIELD_CAP : int'(r.min_digits);
      if (r.flags[itpt_pkg::FLAG_SIGNED] && r.value[31]) begin
        sign_char = itpt_pkg::CHAR_MINUS;
        mag = -r.value;
      end else begin
        mag = r.value;
        sign_char = r.flags[itpt_pkg::FLAG_PLUS] ? itpt_pkg::CHAR_PLUS :
                    (r.flags[itpt_pkg::FLAG_SPACE] ? itpt_pkg::CHAR_SPACE :
                                                     itpt_pkg::CHAR_NUL);
      end
      size = width;
      if (sign_char != itpt_pkg::CHAR_NUL) size = size - 1;
      if (r.flags[itpt_pkg::FLAG_PREFIX]) begin
        if (r.radix == itpt_pkg::RADIX_HEX) size = size - 2;
        else if (r.radix == itpt_pkg::RADIX_OCT) size = size - 1;
      end
      base = 32'(r.radix);
      do begin
        rev_digits.push_back(digit_set[mag % base]);
        mag = mag / base;
      end while (mag != 0);
      nd = rev_digits.size();
      if (prec < nd) prec = nd;
      size = size - prec;
      if (!zero_pad && !left)
        for (i = 0; i < size; i++) text.push_back(itpt_pkg::CHAR_SPACE);
      if (sign_char != itpt_pkg::CHAR_NUL) text.push_back(sign_char);
      if (r.flags[itpt_pkg::FLAG_PREFIX]) begin
        if (r.radix == itpt_pkg::RADIX_OCT) begin
          text.push_back(itpt_pkg::CHAR_ZERO);
        end else if (r.radix == itpt_pkg::RADIX_HEX) begin
          text.push_back(itpt_pkg::CHAR_ZERO);
          text.push_back(digit_set[itpt_pkg::DIGIT_HEX_X]);
        end
      end
      if (zero_pad)
        for (i = 0; i < size; i++) text.push_back(itpt_pkg::CHAR_ZERO);
      for (i = nd; i < prec; i++) text.push_back(itpt_pkg::CHAR_ZERO);
      for (i = nd - 1; i >= 0; i--) text.push_back(rev_digits[i]);
      if (left)
        for (i = 0; i < size; i++) text.push_back(itpt_pkg::CHAR_SPACE);
      n = (text.size() > itpt_pkg::OUT_MAX) ? itpt_pkg::OUT_MAX : text.size();
      for (i = 0; i < n; i++)
        expected_text.push_back('{text[i], i == n - 1, 1'b0});
    endfunction

    function void check_char(text_char_t got);
      text_char_t want;
      if (expected_text.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected character %h last %b bad %b", $realtime,
                   got.text_char, got.last_char, got.bad_radix);
        mismatches++;
        return;
      end
      want = expected_text.pop_front();
      if (got != want) begin
        if (mismatches < 10)
          $display("%0t: expected char %h last %b bad %b, got char %h last %b bad %b",
                   $realtime, want.text_char, want.last_char, want.bad_radix,
                   got.text_char, got.last_char, got.bad_radix);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_value = '0;
  logic [5:0]  in_radix = '0;
  logic [5:0]  in_total_width = '0;
  logic [5:0]  in_min_digits = '0;
  logic [6:0]  in_format_flags = '0;
  logic        out_strobe;
  logic [7:0]  out_text_char;
  logic        out_last_char;
  logic        out_bad_radix;

  field_text_checker text_board;
  int idle_cycles = 0;
  int burst_left = 0;

  integer_to_padded_text_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .in_radix(in_radix),
    .in_total_width(in_total_width),
    .in_min_digits(in_min_digits),
    .in_format_flags(in_format_flags),
    .out_strobe(out_strobe),
    .out_text_char(out_text_char),
    .out_last_char(out_last_char),
    .out_bad_radix(out_bad_radix)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      text_board.check_char('{out_text_char, out_last_char, out_bad_radix});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL integer_to_padded_text_top");
      $finish;
    end
  end

  function automatic fmt_request_t mk(logic [31:0] value, logic [5:0] radix,
                                      logic [5:0] total_width, logic [5:0] min_digits,
                                      logic [6:0] flags);
    fmt_request_t r;
    r = '{value, radix, total_width, min_digits, flags};
    return r;
  endfunction

  function automatic fmt_request_t random_request();
    fmt_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) r.value = $urandom;
    else if (pick < 65) r.value = $urandom_range(0, 40);
    else if (pick < 75) r.value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    else begin
      case ($urandom_range(0, 3))
        0: r.value = 32'h0000_0000;
        1: r.value = 32'h8000_0000;
        2: r.value = 32'h7FFF_FFFF;
        default: r.value = 32'hFFFF_FFFF;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) r.radix = $urandom_range(0, 1);
    else if (pick < 10) r.radix = $urandom_range(37, 63);
    else if (pick < 22) r.radix = itpt_pkg::RADIX_HEX;
    else if (pick < 32) r.radix = itpt_pkg::RADIX_OCT;
    else if (pick < 42) r.radix = RADIX_DEC;
    else if (pick < 46) r.radix = itpt_pkg::RADIX_MIN;
    else r.radix = $urandom_range(itpt_pkg::RADIX_MIN, itpt_pkg::RADIX_MAX);
    pick = $urandom_range(0, 99);
    if (pick < 70) r.total_width = $urandom_range(0, 16);
    else if (pick < 90) r.total_width = $urandom_range(0, 63);
    else r.total_width = $urandom_range(55, 63);
    pick = $urandom_range(0, 99);
    if (pick < 60) r.min_digits = $urandom_range(0, 6);
    else if (pick < 85) r.min_digits = $urandom_range(0, 20);
    else r.min_digits = $urandom_range(0, 63);
    r.flags = $urandom_range(0, 127);
    return r;
  endfunction

  task automatic send_request(fmt_request_t r);
    in_value <= r.value;
    in_radix <= r.radix;
    in_total_width <= r.total_width;
    in_min_digits <= r.min_digits;
    in_format_flags <= r.flags;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    text_board.note_request(r);
  endtask

  task automatic issue(fmt_request_t r);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(1, 6);
    end
    burst_left--;
    send_request(r);
  endtask

  task automatic drain_text();
    start <= 1'b0;
    while (text_board.expected_text.size() != 0) @(posedge clk);
  endtask

  initial begin
    fmt_request_t directed[$];
    text_board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk(32'h0, RADIX_DEC, 6'd0, 6'd0, 7'd0));
    directed.push_back(mk(32'h0, RADIX_DEC, 6'd0, 6'd5, F_PLUS));
    directed.push_back(mk(32'h0, itpt_pkg::RADIX_OCT, 6'd0, 6'd0, F_PREFIX));
    directed.push_back(mk(32'hFFFF_FFFF, itpt_pkg::RADIX_HEX, 6'd0, 6'd0, 7'd0));
    directed.push_back(mk(32'h8000_0000, RADIX_DEC, 6'd0, 6'd0, F_SIGNED));
    directed.push_back(mk(32'h8000_0000, RADIX_DEC, 6'd0, 6'd0, 7'd0));
    directed.push_back(mk(32'hFFFF_FFFF, RADIX_DEC, 6'd6, 6'd0, F_SIGNED | F_ZERO));
    directed.push_back(mk(32'h7FFF_FFFF, itpt_pkg::RADIX_MIN, 6'd63, 6'd63, 7'd0));
    directed.push_back(mk(32'hFFFF_FFFF, itpt_pkg::RADIX_MAX, 6'd12, 6'd0,
                          F_LOWER | F_LEFT | F_ZERO));
    directed.push_back(mk(32'd255, itpt_pkg::RADIX_OCT, 6'd10, 6'd0, F_PREFIX | F_ZERO));
    directed.push_back(mk(32'd255, itpt_pkg::RADIX_HEX, 6'd10, 6'd0, F_PREFIX));
    directed.push_back(mk(32'd255, itpt_pkg::RADIX_HEX, 6'd10, 6'd4,
                          F_PREFIX | F_LOWER | F_LEFT));
    directed.push_back(mk(32'd255, RADIX_DEC, 6'd8, 6'd0, F_PREFIX | F_PLUS));
    directed.push_back(mk(32'd42, RADIX_DEC, 6'd5, 6'd0, F_SPACE));
    directed.push_back(mk(32'd42, RADIX_DEC, 6'd5, 6'd0, F_SPACE | F_PLUS | F_SIGNED));
    directed.push_back(mk(32'h8000_0000, itpt_pkg::RADIX_HEX, 6'd63, 6'd63,
                          F_SIGNED | F_PREFIX | F_ZERO));
    directed.push_back(mk(32'd12345, RADIX_DEC, 6'd3, 6'd8, F_ZERO));
    directed.push_back(mk(32'hDEAD_BEEF, itpt_pkg::RADIX_MAX, 6'd20, 6'd0,
                          F_SIGNED | F_SPACE | F_LEFT));
    directed.push_back(mk(32'h1234_5678, 6'd0, 6'd5, 6'd5, 7'h7F));
    directed.push_back(mk(32'hFFFF_FFFF, 6'd1, 6'd63, 6'd63, F_PREFIX));
    directed.push_back(mk(32'h0, 6'd37, 6'd0, 6'd0, 7'd0));
    directed.push_back(mk(32'hA5A5_A5A5, 6'd63, 6'd60, 6'd60, F_LOWER));
    foreach (directed[i]) issue(directed[i]);
    drain_text();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue(random_request());
      if (i == RANDOM_ITEMS / 2) drain_text();
    end
    drain_text();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (text_board.mismatches == 0 && text_board.expected_text.size() == 0) begin
      $display("PASS integer_to_padded_text_top");
    end else begin
      $display("FAIL integer_to_padded_text_top");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/itpt_pkg.sv
rtl/itpt_div.sv
rtl/integer_to_padded_text_top.sv
test/tb_integer_to_padded_text_top.sv
